/* hdl/fbpa_pkg.sv */
// ============================================================================
// fbpa_pkg
// Shared widths, codes and controller/datapath interface types for the
// fixed block pool allocator.
// ============================================================================
`timescale 1ns / 1ps

package fbpa_pkg;

  // Widths of the external words
  localparam int AddrW    = 32;
  localparam int CountW   = 13;  // holds 0..MaxBlocks
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int StatusW  = 2;

  // Pool geometry
  localparam int MaxBlocks = 4096;
  localparam int StackAw   = $clog2(MaxBlocks);
  localparam int ObjW      = 17;  // object_size register
  localparam int LenW      = 18;  // block length after rounding
  localparam int OffsetW   = 17;  // bump offset
  localparam int PageW     = 17;  // page size in bytes
  localparam int AlignUnit = 16;

  localparam logic [PageW-1:0]  SmallPage     = PageW'(4096);
  localparam logic [PageW-1:0]  LargePage     = PageW'(64 * 1024);
  localparam logic [ObjW-1:0]   ResetObjSize  = ObjW'(16);
  localparam logic [CountW-1:0] ResetCapacity = CountW'(4096 / 16);

  // Capacity divider: one quotient bit per step
  localparam int QuoW     = PageW;
  localparam int RemW     = LenW;
  localparam int DivSteps = QuoW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // Operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusFull      = 2'd1;
  localparam logic [StatusW-1:0] StatusUnderflow = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgBase      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPageLarge = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAlign     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgObjSize   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;       // run the accepted word
    logic pop_done;   // stack read data is valid, finish the pop
    logic div_start;  // start the capacity divider
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_pop;   // current word pops the free stack
    logic div_done;   // capacity divider finished
  } dp_status_t;

endpackage

/* hdl/fbpa_ram.sv */
// ============================================================================
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fbpa_div.sv */
// ============================================================================
// fbpa_div
// Restoring divider for page size / block length, one quotient bit a cycle.
// ============================================================================
`timescale 1ns / 1ps

module fbpa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fbpa_pkg::PageW-1:0]   dividend_i,
  input  logic [fbpa_pkg::LenW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [fbpa_pkg::QuoW-1:0]    quotient_o
);

  import fbpa_pkg::*;

  logic [RemW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [LenW-1:0]    den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [RemW:0]      trial;

  // Load the operands on start, else shift in the next dividend bit and try a subtract
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[QuoW-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      den_d = divisor_i;
      cnt_d = DivCntW'(DivSteps);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = RemW'(trial - {1'b0, den_q});
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[RemW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DivCntW'(1);
      done_d = (cnt_q == DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/fbpa_datapath.sv */
// ============================================================================
// fbpa_datapath
// Configuration registers, pool counters, free stack and result registers.
// ============================================================================
`timescale 1ns / 1ps

module fbpa_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbpa_pkg::ctrl_cmd_t            cmd_i,
  output fbpa_pkg::dp_status_t           sts_o,
  input  logic                           op_i,
  input  logic [fbpa_pkg::AddrW-1:0]     chunk_address_i,
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           done_o,
  output logic [fbpa_pkg::AddrW-1:0]     block_address_o,
  output logic [fbpa_pkg::StatusW-1:0]   status_o,
  output logic [fbpa_pkg::CountW-1:0]    blocks_in_use_o
);

  import fbpa_pkg::*;

  // Block length: zero size counts as one byte, optional round up to 16
  function automatic logic [LenW-1:0] calc_len(input logic [ObjW-1:0] obj,
                                               input logic            align);
    logic [LenW-1:0] len;
    logic [LenW-1:0] rounded;
    len     = (obj == '0) ? LenW'(1) : LenW'(obj);
    rounded = (len + LenW'(AlignUnit - 1)) & ~LenW'(AlignUnit - 1);
    return align ? rounded : len;
  endfunction

  logic [AddrW-1:0]   base_q, base_d;
  logic               page_large_q, page_large_d;
  logic               align_q, align_d;
  logic [ObjW-1:0]    obj_size_q, obj_size_d;
  logic [CountW-1:0]  capacity_q, capacity_d;
  logic [CountW-1:0]  free_count_q, free_count_d;
  logic [OffsetW-1:0] bump_q, bump_d;
  logic [CountW-1:0]  in_use_q, in_use_d;
  logic               done_q, done_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [StatusW-1:0] status_q, status_d;

  logic [LenW-1:0]    block_len;
  logic [LenW-1:0]    bump_sum;
  logic [CountW-1:0]  pop_idx;
  logic               is_alloc;
  logic               is_full;
  logic               push_ok;
  logic               need_pop;
  logic               stack_we;
  logic               stack_re;
  logic [AddrW-1:0]   stack_rdata;
  logic [PageW-1:0]   page_size;
  logic               div_done;
  logic [QuoW-1:0]    quotient;

  assign block_len = calc_len(obj_size_q, align_q);
  assign bump_sum  = LenW'(bump_q) + block_len;
  assign pop_idx   = free_count_q - CountW'(1);
  assign is_alloc  = (op_i == OpAlloc);
  assign is_full   = (in_use_q >= capacity_q);
  assign push_ok   = (free_count_q < CountW'(MaxBlocks));
  assign need_pop  = is_alloc && !is_full && (free_count_q != '0);
  assign page_size = page_large_q ? LargePage : SmallPage;

  // Stack port controls
  assign stack_we = cmd_i.exec && !is_alloc && (in_use_q != '0) && push_ok;
  assign stack_re = cmd_i.exec && need_pop;

  fbpa_ram #(
    .Width (AddrW),
    .Depth (MaxBlocks)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (free_count_q[StackAw-1:0]),
    .wdata_i (chunk_address_i),
    .re_i    (stack_re),
    .raddr_i (pop_idx[StackAw-1:0]),
    .rdata_o (stack_rdata)
  );

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (page_size),
    .divisor_i  (block_len),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next-state for registers, counters and the result word
  always_comb begin
    base_d       = base_q;
    page_large_d = page_large_q;
    align_d      = align_q;
    obj_size_d   = obj_size_q;
    capacity_d   = capacity_q;
    free_count_d = free_count_q;
    bump_d       = bump_q;
    in_use_d     = in_use_q;
    done_d       = 1'b0;
    addr_d       = addr_q;
    status_d     = status_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBase:      base_d       = cfg_data_i;
        CfgPageLarge: page_large_d = cfg_data_i[0];
        CfgAlign:     align_d      = cfg_data_i[0];
        CfgObjSize:   obj_size_d   = cfg_data_i[ObjW-1:0];
        default:      base_d       = base_q;
      endcase
      free_count_d = '0;
      bump_d       = '0;
      in_use_d     = '0;
    end else if (cmd_i.exec) begin
      if (is_alloc) begin
        if (is_full) begin
          done_d   = 1'b1;
          addr_d   = '0;
          status_d = StatusFull;
        end else if (need_pop) begin
          // result follows once the stack read returns
          free_count_d = pop_idx;
          in_use_d     = in_use_q + CountW'(1);
        end else begin
          done_d   = 1'b1;
          addr_d   = base_q + AddrW'(bump_q);
          status_d = StatusOk;
          bump_d   = bump_sum[OffsetW-1:0];
          in_use_d = in_use_q + CountW'(1);
        end
      end else begin
        done_d = 1'b1;
        addr_d = '0;
        if (in_use_q == '0) begin
          status_d = StatusUnderflow;
        end else begin
          status_d = StatusOk;
          in_use_d = in_use_q - CountW'(1);
          if (push_ok) begin
            free_count_d = free_count_q + CountW'(1);
          end
        end
      end
    end else if (cmd_i.pop_done) begin
      done_d   = 1'b1;
      addr_d   = stack_rdata;
      status_d = StatusOk;
    end

    // Capacity saturates at the stack depth
    if (div_done) begin
      capacity_d = (quotient > QuoW'(MaxBlocks)) ? CountW'(MaxBlocks)
                                                 : quotient[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      page_large_q <= 1'b0;
      align_q      <= 1'b0;
      obj_size_q   <= ResetObjSize;
      capacity_q   <= ResetCapacity;
      free_count_q <= '0;
      bump_q       <= '0;
      in_use_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      base_q       <= base_d;
      page_large_q <= page_large_d;
      align_q      <= align_d;
      obj_size_q   <= obj_size_d;
      capacity_q   <= capacity_d;
      free_count_q <= free_count_d;
      bump_q       <= bump_d;
      in_use_q     <= in_use_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    status_q <= status_d;
  end

  assign sts_o.need_pop = need_pop;
  assign sts_o.div_done = div_done;

  assign done_o          = done_q;
  assign block_address_o = addr_q;
  assign status_o        = status_q;
  assign blocks_in_use_o = in_use_q;

endmodule

/* hdl/fbpa_ctrl.sv */
// ============================================================================
// fbpa_ctrl
// Controller: accepts words, waits on stack reads and capacity rebuilds.
// ============================================================================
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  cfg_we_i,
  input  fbpa_pkg::dp_status_t  sts_i,
  output fbpa_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);

  import fbpa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.exec      = 1'b0;
    cmd_o.pop_done  = 1'b0;
    cmd_o.div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.exec = 1'b1;
          if (sts_i.need_pop) begin
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write always rebuilds the pool
    if (cfg_we_i) begin
      cmd_o.exec     = 1'b0;
      cmd_o.pop_done = 1'b0;
      state_d        = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* hdl/fixed_block_pool_allocator_core.sv */
// ============================================================================
// fixed_block_pool_allocator_core
// Fixed-size block allocator over one page, LIFO free stack plus bump pointer.
// ============================================================================
//
//  channel   handshake            word
//  -------   ------------------   ----------------------------------------
//  request   start & !busy        op_i, chunk_address_i
//  result    done_o (one cycle)   block_address_o, status_o, blocks_in_use_o
//  config    cfg_we_i             cfg_index_i, cfg_data_i
//
//  A free, a bump allocate or a rejected word shows its result the cycle
//  after the accept, and the next word may come then.
//  A free-stack allocate waits in ST_POP for the registered RAM read.
//  A register write rebuilds capacity with a bit-serial divider; busy stays
//  high through ST_LOAD and ST_DIV. Reset gives capacity 256 with no rebuild.
//  Results cannot be stalled; the result registers hold until the next word.
//
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op_i,
  input  logic [fbpa_pkg::AddrW-1:0]     chunk_address_i,
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           done_o,
  output logic [fbpa_pkg::AddrW-1:0]     block_address_o,
  output logic [fbpa_pkg::StatusW-1:0]   status_o,
  output logic [fbpa_pkg::CountW-1:0]    blocks_in_use_o
);

  import fbpa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_we_i (cfg_we_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fbpa_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .chunk_address_i (chunk_address_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .block_address_o (block_address_o),
    .status_o        (status_o),
    .blocks_in_use_o (blocks_in_use_o)
  );

endmodule
